[sv/gld_pkg.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared codes, widths and defaults for the LZW image data decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

   localparam int DictEntriesDefault = 4096;
   localparam int StackDepthDefault  = 4096;
   localparam int CodeW              = 13;
   localparam int MaxCodeWidth       = 12;
   localparam logic [12:0] NoneCode  = 13'h1001;

   typedef enum logic [1:0] {
      FN_START = 2'd0,
      FN_BYTE  = 2'd1,
      FN_PULL  = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_REFUSED  = 3'd1,
      ST_PIXEL    = 3'd2,
      ST_NEED     = 3'd3,
      ST_DONE     = 3'd4,
      ST_BAD      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_SIZE   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2,
      PH_ENDED  = 2'd3
   } phase_type;

endpackage

[sv/gld_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module gld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/gif_lzw_decoder.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Decodes the LZW data of one GIF image into colour indices, at most one per pull.
// ----------------------------------------------------------------------------
// Usage: write image_width (index 0) and image_height (index 1) on the csr
// port, send a start word, then the stream bytes (code size, sub-blocks,
// zero-length terminator) and pull words. Every request word yields exactly
// one response word on the rsp channel.
// Start and byte words are answered straight from the idle state. A pull that
// finds no code size yet or a finished image answers from the check state, one
// served from the pixel stack from the pop state. A pull that reads a code
// answers from the code state on need data, a bad code, the end code or the
// first code after a clear. Any other code walks the prefix/suffix memories in
// the walk state, one entry per cycle, as far as the string needs, and answers
// from the finish state, or from the pop state when the pixel stack is full.
// Clear codes in front are taken in the code state. One word at a time is in flight.
// Reset clears all control state; table and stack memories are not cleared
// and need no clearing pass. A start word clears the decoder state.
// When rsp_stall is held the response word waits in the output register and
// a new request is taken in the cycle the old response leaves.
// ----------------------------------------------------------------------------
module gif_lzw_decoder #(
   parameter int DICT_ENTRIES = gld_pkg::DictEntriesDefault,
   parameter int STACK_DEPTH  = gld_pkg::StackDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_pixel,
   output logic [31:0] rsp_pixel_index
);

   localparam int TAW = $clog2(DICT_ENTRIES);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = SAW + 1;
   localparam int CW  = gld_pkg::CodeW;
   localparam logic [CW-1:0]  DictLimit  = CW'(DICT_ENTRIES);
   localparam logic [SPW-1:0] StackLimit = SPW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_CODE, S_WALK, S_FINISH, S_POP
   } state_type;

   state_type            state_ff, state_in;
   logic [15:0]          width_ff, width_in, height_ff, height_in;
   logic [31:0]          total_ff;
   logic [SPW-1:0]       sp_ff, sp_in;
   logic [31:0]          buf_ff, buf_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [3:0]           cwid_ff, cwid_in;
   logic [3:0]           root_ff, root_in;
   logic [CW-1:0]        next_ff, next_in;
   logic [CW-1:0]        prev_ff, prev_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        walk_ff, walk_in;
   logic [7:0]           first_ff, first_in;
   logic [7:0]           left_ff, left_in;
   logic [31:0]          done_ff, done_in;
   gld_pkg::phase_type   phase_ff, phase_in;
   logic                 end_ff, end_in;
   logic                 rv_ff, rv_in;
   gld_pkg::status_type  rst_ff, rst_in;
   logic [7:0]           rpx_ff, rpx_in;
   logic [31:0]          ridx_ff, ridx_in;

   logic                 req_take;
   logic [CW-1:0]        clear_code, code, first_code, ne1;
   logic [31:0]          mask;
   logic [3:0]           sat;
   logic                 tbl_we;
   logic [TAW-1:0]       tbl_waddr, tbl_raddr;
   logic [TAW-1:0]       pre_wdata, pre_rdata;
   logic [7:0]           suf_wdata, suf_rdata;
   logic                 stk_we;
   logic [SAW-1:0]       stk_waddr, stk_raddr;
   logic [7:0]           stk_wdata, stk_rdata;

   gld_ram #(.WIDTH(TAW), .DEPTH(DICT_ENTRIES)) u_prefix (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(pre_wdata),
      .rd_addr(tbl_raddr), .rd_data(pre_rdata));

   gld_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(suf_wdata),
      .rd_addr(tbl_raddr), .rd_data(suf_rdata));

   gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rst_ff;
   assign rsp_pixel       = rpx_ff;
   assign rsp_pixel_index = ridx_ff;

   assign clear_code = CW'(1) << root_ff;
   assign mask       = (32'd1 << cwid_ff) - 32'd1;
   assign code       = CW'(buf_ff & mask);
   assign first_code = walk_ff;
   assign ne1        = next_ff + CW'(1);
   assign sat        = (req_data_byte < 8'd2) ? 4'd2 :
                       (req_data_byte > 8'd8) ? 4'd8 : req_data_byte[3:0];

   always_comb begin
      logic [CW-1:0] c0;
      logic [CW-1:0] cn;
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      sp_in     = sp_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      cwid_in   = cwid_ff;
      root_in   = root_ff;
      next_in   = next_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      walk_in   = walk_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      done_in   = done_ff;
      phase_in  = phase_ff;
      end_in    = end_ff;
      rv_in     = rv_ff && rsp_stall;
      rst_in    = rst_ff;
      rpx_in    = rpx_ff;
      ridx_in   = ridx_ff;
      tbl_we    = 1'b0;
      tbl_waddr = next_ff[TAW-1:0];
      tbl_raddr = walk_ff[TAW-1:0];
      pre_wdata = prev_ff[TAW-1:0];
      suf_wdata = first_code[7:0];
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SAW-1:0];
      stk_wdata = first_ff;
      stk_raddr = SAW'(sp_ff - SPW'(1));
      c0        = '0;
      cn        = '0;

      if (csr_write_enable) begin
         if (csr_index) begin
            height_in = csr_write_data;
         end else begin
            width_in = csr_write_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rv_in  = 1'b1;
               rpx_in = '0;
               ridx_in = '0;
               rst_in = gld_pkg::ST_REFUSED;
               case (gld_pkg::func_type'(req_func))
                  gld_pkg::FN_START: begin
                     rst_in   = gld_pkg::ST_ACCEPTED;
                     sp_in    = '0;
                     buf_in   = '0;
                     cnt_in   = '0;
                     cwid_in  = '0;
                     root_in  = '0;
                     next_in  = '0;
                     prev_in  = gld_pkg::NoneCode;
                     first_in = '0;
                     left_in  = '0;
                     done_in  = '0;
                     phase_in = gld_pkg::PH_SIZE;
                     end_in   = 1'b0;
                  end
                  gld_pkg::FN_BYTE: begin
                     case (phase_ff)
                        gld_pkg::PH_SIZE: begin
                           rst_in   = gld_pkg::ST_ACCEPTED;
                           root_in  = sat;
                           cwid_in  = sat + 4'd1;
                           next_in  = (CW'(1) << sat) + CW'(2);
                           prev_in  = gld_pkg::NoneCode;
                           phase_in = gld_pkg::PH_LENGTH;
                        end
                        gld_pkg::PH_LENGTH: begin
                           rst_in  = gld_pkg::ST_ACCEPTED;
                           left_in = req_data_byte;
                           phase_in = (req_data_byte == 8'd0) ? gld_pkg::PH_ENDED
                                                              : gld_pkg::PH_DATA;
                        end
                        gld_pkg::PH_DATA: begin
                           if (cnt_ff <= 6'd24) begin
                              rst_in  = gld_pkg::ST_ACCEPTED;
                              buf_in  = buf_ff | (32'(req_data_byte) << cnt_ff);
                              cnt_in  = cnt_ff + 6'd8;
                              left_in = left_ff - 8'd1;
                              if (left_ff == 8'd1) begin
                                 phase_in = gld_pkg::PH_LENGTH;
                              end
                           end
                        end
                        default: rst_in = gld_pkg::ST_REFUSED;
                     endcase
                  end
                  gld_pkg::FN_PULL: begin
                     rv_in    = 1'b0;
                     state_in = S_CHECK;
                  end
                  default: rst_in = gld_pkg::ST_REFUSED;
               endcase
            end
         end

         S_CHECK: begin
            if (phase_ff == gld_pkg::PH_SIZE) begin
               rv_in = 1'b1; rst_in = gld_pkg::ST_NEED; state_in = S_IDLE;
            end else if (end_ff || done_ff >= total_ff) begin
               rv_in = 1'b1; rst_in = gld_pkg::ST_DONE; state_in = S_IDLE;
            end else if (sp_ff != '0) begin
               // pop: read the top entry, data arrives next cycle
               sp_in    = sp_ff - SPW'(1);
               state_in = S_POP;
            end else begin
               state_in = S_CODE;
            end
         end

         S_CODE: begin
            if ({2'b00, cwid_ff} > cnt_ff) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
               if (phase_ff == gld_pkg::PH_ENDED) begin
                  end_in = 1'b1;
                  rst_in = gld_pkg::ST_DONE;
               end else begin
                  rst_in = gld_pkg::ST_NEED;
               end
            end else begin
               buf_in = buf_ff >> cwid_ff;
               cnt_in = cnt_ff - {2'b00, cwid_ff};
               if (code == clear_code) begin
                  cwid_in = root_ff + 4'd1;
                  next_in = clear_code + CW'(2);
                  prev_in = gld_pkg::NoneCode;
               end else if (code == clear_code + CW'(1)) begin
                  end_in = 1'b1;
                  rv_in = 1'b1; rst_in = gld_pkg::ST_DONE; state_in = S_IDLE;
               end else if (prev_ff == gld_pkg::NoneCode) begin
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
                  if (code > clear_code) begin
                     rst_in = gld_pkg::ST_BAD;
                  end else begin
                     first_in = code[7:0];
                     prev_in  = code;
                     rst_in   = gld_pkg::ST_PIXEL;
                     rpx_in   = code[7:0];
                     ridx_in  = done_ff;
                     done_in  = done_ff + 32'd1;
                  end
               end else if (code > next_ff || code >= DictLimit) begin
                  rv_in = 1'b1; rst_in = gld_pkg::ST_BAD; state_in = S_IDLE;
               end else begin
                  cur_in = code;
                  c0     = code;
                  if (code == next_ff) begin
                     // code not yet in table: lead with the first pixel
                     c0 = prev_ff;
                     if (sp_ff < StackLimit) begin
                        stk_we = 1'b1;
                        sp_in  = sp_ff + SPW'(1);
                     end
                  end
                  walk_in   = c0;
                  tbl_raddr = c0[TAW-1:0];
                  state_in  = (c0 >= clear_code + CW'(2)) ? S_WALK : S_FINISH;
               end
            end
         end

         S_WALK: begin
            stk_wdata = suf_rdata;
            if (sp_ff < StackLimit) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + SPW'(1);
            end
            cn        = CW'(pre_rdata);
            walk_in   = cn;
            tbl_raddr = cn[TAW-1:0];
            if (cn < clear_code + CW'(2)) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            first_in  = first_code[7:0];
            stk_wdata = first_code[7:0];
            if (next_ff < DictLimit) begin
               tbl_we  = 1'b1;
               next_in = ne1;
               if (ne1 < DictLimit && (ne1 & ((CW'(1) << cwid_ff) - CW'(1))) == '0
                   && cwid_ff < 4'(gld_pkg::MaxCodeWidth)) begin
                  cwid_in = cwid_ff + 4'd1;
               end
            end
            prev_in = cur_ff;
            if (sp_ff < StackLimit) begin
               // push and pop cancel: forward the first pixel
               stk_we   = 1'b1;
               rv_in    = 1'b1;
               rst_in   = gld_pkg::ST_PIXEL;
               rpx_in   = first_code[7:0];
               ridx_in  = done_ff;
               done_in  = done_ff + 32'd1;
               state_in = S_IDLE;
            end else begin
               sp_in     = StackLimit - SPW'(1);
               stk_raddr = SAW'(StackLimit - SPW'(1));
               state_in  = S_POP;
            end
         end

         S_POP: begin
            rv_in    = 1'b1;
            rst_in   = gld_pkg::ST_PIXEL;
            rpx_in   = stk_rdata;
            ridx_in  = done_ff;
            done_in  = done_ff + 32'd1;
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= '0;
         height_ff <= '0;
         sp_ff     <= '0;
         buf_ff    <= '0;
         cnt_ff    <= '0;
         cwid_ff   <= '0;
         root_ff   <= '0;
         next_ff   <= '0;
         prev_ff   <= gld_pkg::NoneCode;
         first_ff  <= '0;
         left_ff   <= '0;
         done_ff   <= '0;
         phase_ff  <= gld_pkg::PH_SIZE;
         end_ff    <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         sp_ff     <= sp_in;
         buf_ff    <= buf_in;
         cnt_ff    <= cnt_in;
         cwid_ff   <= cwid_in;
         root_ff   <= root_in;
         next_ff   <= next_in;
         prev_ff   <= prev_in;
         first_ff  <= first_in;
         left_ff   <= left_in;
         done_ff   <= done_in;
         phase_ff  <= phase_in;
         end_ff    <= end_in;
         rv_ff     <= rv_in;
      end
      total_ff <= 32'(width_ff) * 32'(height_ff);
      cur_ff   <= cur_in;
      walk_ff  <= walk_in;
      rst_ff   <= rst_in;
      rpx_ff   <= rpx_in;
      ridx_ff  <= ridx_in;
   end

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= StackLimit)
      else $error("pixel stack pointer beyond depth");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |-> state_ff == S_IDLE)
      else $error("request taken while busy");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'd32 && cwid_ff <= 4'(gld_pkg::MaxCodeWidth))
      else $error("bit count or code width out of range");

   a_walk_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> walk_ff < next_ff)
      else $error("table walk reached an unwritten entry");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK || state_ff == S_WALK) |-> !rv_ff)
      else $error("response pending during decode");

endmodule

[tb/tb_gif_lzw_decoder.sv]
// ----------------------------------------------------------------------------
// GIF LZW decoder testbench
// Sends start, stream byte and pull words to the decoder and checks every
// response word against a decoder model in the bench or, for typed rows, the
// status in the row. A short table of hand-made words comes first. Then whole
// images follow, built by a code generator that tracks table growth and code
// width. Noise words and bad codes are mixed in, and one longer image grows the
// code width at the largest geometry. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_gif_lzw_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Entries    = 4096;
   localparam int WatchLimit = 20000;

   typedef struct {
      gld_pkg::status_type st;
      logic [7:0]          px;
      logic [31:0]         idx;
   } pixel_word_type;

   typedef struct {
      gld_pkg::func_type   f;
      logic [7:0]          b;
      bit                  typed;
      gld_pkg::status_type st;
   } steer_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = gld_pkg::FN_NONE;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_pixel;
   logic [31:0] rsp_pixel_index;

   gif_lzw_decoder dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder model state
   logic [11:0]  pfx_mem [Entries];
   logic [7:0]   sfx_mem [Entries];
   logic [7:0]   pix_stack [Entries];
   int unsigned  sp, bits, cw, rootb, nxt, prevc, firstpx, blk_left, px_done;
   logic [31:0]  bitbuf;
   gld_pkg::phase_type ph;
   bit           end_seen;
   logic [15:0]  img_w, img_h;

   pixel_word_type pending_words [$];
   logic [7:0]   plan_bytes [$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   bit           pressure_req = 0;
   bit           pressure_taken = 0;
   int           hold_left = 0;
   int           idle_count = 0;

   function automatic void clear_image();
      for (int i = 0; i < 256; i++) sfx_mem[i] = i[7:0];
      sp = 0; bitbuf = '0; bits = 0; cw = 0; rootb = 0; nxt = 0;
      prevc = 32'(gld_pkg::NoneCode); firstpx = 0; blk_left = 0; px_done = 0;
      ph = gld_pkg::PH_SIZE; end_seen = 0;
   endfunction

   function automatic void push_px(int unsigned v);
      if (sp < Entries) begin
         pix_stack[sp] = v[7:0];
         sp++;
      end
   endfunction

   function automatic pixel_word_type emit_pixel(int unsigned v);
      pixel_word_type r;
      r.st = gld_pkg::ST_PIXEL;
      r.px = v[7:0];
      r.idx = px_done;
      px_done++;
      return r;
   endfunction

   function automatic bit image_finished();
      int unsigned total;
      total = int'(img_w) * int'(img_h);
      return end_seen || px_done >= total;
   endfunction

   function automatic gld_pkg::status_type take_byte(int unsigned b);
      int unsigned r;
      case (ph)
         gld_pkg::PH_SIZE: begin
            r = b < 2 ? 2 : (b > 8 ? 8 : b);
            rootb = r; cw = r + 1; nxt = (1 << r) + 2; prevc = 32'(gld_pkg::NoneCode);
            ph = gld_pkg::PH_LENGTH;
            return gld_pkg::ST_ACCEPTED;
         end
         gld_pkg::PH_LENGTH: begin
            if (b == 0) ph = gld_pkg::PH_ENDED;
            else begin
               blk_left = b;
               ph = gld_pkg::PH_DATA;
            end
            return gld_pkg::ST_ACCEPTED;
         end
         gld_pkg::PH_DATA: begin
            if (bits > 24) return gld_pkg::ST_REFUSED;
            bitbuf |= b << bits;
            bits += 8;
            blk_left--;
            if (blk_left == 0) ph = gld_pkg::PH_LENGTH;
            return gld_pkg::ST_ACCEPTED;
         end
         default: return gld_pkg::ST_REFUSED;
      endcase
   endfunction

   function automatic pixel_word_type decode_pull();
      pixel_word_type r;
      int unsigned clr, code, cur, c, steps;
      r = '{gld_pkg::ST_NEED, 8'd0, 32'd0};
      if (ph == gld_pkg::PH_SIZE) return r;
      r.st = gld_pkg::ST_DONE;
      if (image_finished()) return r;
      if (sp > 0) begin
         sp--;
         return emit_pixel(32'(pix_stack[sp]));
      end
      while (1) begin
         if (bits < cw) begin
            if (ph == gld_pkg::PH_ENDED) begin
               end_seen = 1;
               r.st = gld_pkg::ST_DONE;
            end else r.st = gld_pkg::ST_NEED;
            return r;
         end
         code = bitbuf & ((1 << cw) - 1);
         bitbuf >>= cw;
         bits -= cw;
         clr = 1 << rootb;
         if (code == clr) begin
            cw = rootb + 1; nxt = clr + 2; prevc = 32'(gld_pkg::NoneCode);
            continue;
         end
         if (code == clr + 1) begin
            end_seen = 1;
            r.st = gld_pkg::ST_DONE;
            return r;
         end
         r.st = gld_pkg::ST_BAD;
         if (prevc == 32'(gld_pkg::NoneCode)) begin
            if (code > clr) return r;
            firstpx = code; prevc = code;
            return emit_pixel(code);
         end
         if (code > nxt || code >= Entries) return r;
         cur = code;
         c = code;
         // code not yet in the table: repeat the first pixel of the last string
         if (code == nxt) begin
            push_px(firstpx);
            c = prevc;
         end
         steps = 0;
         while (c >= clr + 2 && c < Entries && steps < Entries) begin
            push_px(32'(sfx_mem[c]));
            c = 32'(pfx_mem[c]);
            steps++;
         end
         firstpx = c < Entries ? 32'(sfx_mem[c]) : 32'd0;
         push_px(firstpx);
         if (nxt < Entries) begin
            sfx_mem[nxt] = firstpx[7:0];
            pfx_mem[nxt] = prevc[11:0];
            nxt++;
            if (nxt < Entries && (nxt & ((1 << cw) - 1)) == 0 &&
                cw < gld_pkg::MaxCodeWidth)
               cw++;
         end
         prevc = cur;
         sp--;
         return emit_pixel(32'(pix_stack[sp]));
      end
      return r;
   endfunction

   function automatic pixel_word_type predict_word(gld_pkg::func_type f, logic [7:0] b);
      pixel_word_type r;
      r = '{gld_pkg::ST_REFUSED, 8'd0, 32'd0};
      case (f)
         gld_pkg::FN_START: begin
            clear_image();
            r.st = gld_pkg::ST_ACCEPTED;
         end
         gld_pkg::FN_BYTE: r.st = take_byte(32'(b));
         gld_pkg::FN_PULL: r = decode_pull();
         default: ;
      endcase
      return r;
   endfunction

   // build the stream bytes of one image, tracking the table as a decoder would
   function automatic void plan_image(int unsigned size_byte, int unsigned ncodes,
                                      int unsigned root_pct, int unsigned clear_pct);
      int unsigned rb, clr, gw, gn, code, hi, w0, len, max_len;
      bit none, skip;
      logic [63:0] acc;
      int nb;
      logic [7:0] data [$];
      rb = size_byte < 2 ? 2 : (size_byte > 8 ? 8 : size_byte);
      clr = 1 << rb; gw = rb + 1; gn = clr + 2; none = 1;
      acc = '0; nb = 0;
      for (int i = 0; i < ncodes; i++) begin
         w0 = gw; skip = 0; hi = (1 << gw) - 1;
         if (i == 0 ? $urandom_range(4) != 0 : $urandom_range(99) < clear_pct) begin
            code = clr; gw = rb + 1; gn = clr + 2; none = 1;
         end else if ($urandom_range(99) < 3) begin
            if (none) code = $urandom_range(hi, clr + 2);
            else if (gn + 1 <= hi) code = $urandom_range(hi, gn + 1);
            else skip = 1;
         end else if (none) begin
            code = $urandom_range(clr - 1, 0);
            none = 0;
         end else begin
            code = $urandom_range(99) < root_pct ? $urandom_range(clr - 1, 0)
                                                 : $urandom_range(gn, 0);
            if (code == clr || code == clr + 1) code = gn;
            if (code >= Entries) code = Entries - 1;
            if (gn < Entries) begin
               gn++;
               if (gn < Entries && (gn & ((1 << gw) - 1)) == 0 &&
                   gw < gld_pkg::MaxCodeWidth) gw++;
            end
         end
         if (!skip) begin
            acc |= 64'(code) << nb;
            nb += w0;
         end
         while (nb >= 8) begin
            data.push_back(acc[7:0]);
            acc >>= 8;
            nb -= 8;
         end
      end
      if ($urandom_range(3) != 0) begin
         acc |= 64'(clr + 1) << nb;
         nb += gw;
      end
      while (nb > 0) begin
         data.push_back(acc[7:0]);
         acc >>= 8;
         nb -= 8;
      end
      plan_bytes.delete();
      plan_bytes.push_back(size_byte[7:0]);
      while (data.size() > 0) begin
         max_len = $urandom_range(9) == 0 ? 255 : 8;
         len = $urandom_range(max_len, 1);
         if (len > data.size()) len = data.size();
         plan_bytes.push_back(len[7:0]);
         repeat (len) plan_bytes.push_back(data.pop_front());
      end
      if ($urandom_range(9) != 0) plan_bytes.push_back(8'd0);
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
   endtask

   task automatic send_word(input gld_pkg::func_type f, input logic [7:0] b,
                            input bit typed, input gld_pkg::status_type tst,
                            output gld_pkg::status_type got_st);
      pixel_word_type w;
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = predict_word(f, b);
      if (typed) w = '{tst, 8'd0, 32'd0};
      pending_words.push_back(w);
      got_st = w.st;
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(logic [15:0] w, logic [15:0] h);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= 1'b0;
      csr_write_data <= w;
      @(posedge clock);
      csr_index <= 1'b1;
      csr_write_data <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      img_w = w;
      img_h = h;
   endtask

   task automatic run_image(int unsigned size_byte, int unsigned ncodes,
                            int unsigned root_pct, int unsigned clear_pct);
      gld_pkg::status_type st;
      int i, guard;
      send_word(gld_pkg::FN_START, 8'($urandom), 1'b0, gld_pkg::ST_ACCEPTED, st);
      plan_image(size_byte, ncodes, root_pct, clear_pct);
      i = 0;
      while (i < plan_bytes.size()) begin
         if ($urandom_range(99) < 3)
            send_word(gld_pkg::func_type'($urandom_range(3, 1)), 8'($urandom), 1'b0,
                      gld_pkg::ST_ACCEPTED, st);
         else if ((ph == gld_pkg::PH_DATA && bits > 24 && !image_finished()) ||
                  $urandom_range(2) == 0)
            send_word(gld_pkg::FN_PULL, 8'($urandom), 1'b0, gld_pkg::ST_ACCEPTED, st);
         else begin
            send_word(gld_pkg::FN_BYTE, plan_bytes[i], 1'b0, gld_pkg::ST_ACCEPTED, st);
            i++;
         end
      end
      // empty the stack and the bit buffer
      guard = 0;
      do begin
         send_word(gld_pkg::FN_PULL, 8'($urandom), 1'b0, gld_pkg::ST_ACCEPTED, st);
         guard++;
      end while (st != gld_pkg::ST_DONE && st != gld_pkg::ST_NEED && guard < 40000);
   endtask

   // receiver: check each word leaving the block, then pick the next stall
   always @(posedge clock) begin
      pixel_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0)
            report_mismatch("unexpected word", 32'(rsp_status), 32'd0);
         else begin
            w = pending_words.pop_front();
            if (rsp_status !== w.st)
               report_mismatch("status", 32'(rsp_status), 32'(w.st));
            if (rsp_pixel !== w.px)
               report_mismatch("pixel", 32'(rsp_pixel), 32'(w.px));
            if (rsp_pixel_index !== w.idx)
               report_mismatch("pixel_index", rsp_pixel_index, w.idx);
         end
      end
      if (pressure_req && !pressure_taken) begin
         pressure_taken = 1;
         hold_left = 300;
      end
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= $urandom_range(99) < recv_idle_pct;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= WatchLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   steer_row_type steer_rows [26] = '{
      '{gld_pkg::FN_PULL,  8'h00, 1'b1, gld_pkg::ST_NEED},
      '{gld_pkg::FN_NONE,  8'h5a, 1'b1, gld_pkg::ST_REFUSED},
      '{gld_pkg::FN_START, 8'h00, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h00, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h02, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h8c, 1'b0, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h05, 1'b0, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL},
      '{gld_pkg::FN_BYTE,  8'h00, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_PULL,  8'hff, 1'b1, gld_pkg::ST_DONE},
      '{gld_pkg::FN_BYTE,  8'h33, 1'b1, gld_pkg::ST_REFUSED},
      '{gld_pkg::FN_START, 8'hff, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'hff, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_PULL,  8'h00, 1'b1, gld_pkg::ST_NEED},
      '{gld_pkg::FN_BYTE,  8'h01, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_START, 8'h00, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h02, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h01, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_BYTE,  8'h07, 1'b1, gld_pkg::ST_ACCEPTED},
      '{gld_pkg::FN_PULL,  8'h00, 1'b1, gld_pkg::ST_BAD},
      '{gld_pkg::FN_PULL,  8'h00, 1'b0, gld_pkg::ST_PIXEL}
   };

   initial begin
      gld_pkg::status_type st;
      int mark;
      logic [15:0] gw, gh;
      img_w = '0;
      img_h = '0;
      clear_image();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_geometry(16'd3, 16'd5);
      foreach (steer_rows[i])
         send_word(steer_rows[i].f, steer_rows[i].b, steer_rows[i].typed,
                   steer_rows[i].st, st);

      for (int m = 0; m < 3; m++) begin
         send_idle_pct = m == 0 ? 16 : (m == 1 ? 87 : 0);
         recv_idle_pct = m == 0 ? 87 : (m == 1 ? 16 : 0);
         if (m == 2) begin
            // longer image: grow the code width, with a receiver hold-off at the start
            set_geometry(16'hffff, 16'hffff);
            pressure_req = 1;
            run_image(2, 150, 80, 0);
         end
         mark = items_sent;
         while (items_sent - mark < 180) begin
            if ($urandom_range(2) == 0) begin
               case ($urandom_range(5))
                  0: begin gw = 16'd0; gh = 16'd0; end
                  1: begin gw = 16'd1; gh = 16'd1; end
                  2: begin gw = 16'hffff; gh = 16'hffff; end
                  default: begin
                     gw = 16'($urandom_range(12, 1));
                     gh = 16'($urandom_range(12, 1));
                  end
               endcase
               set_geometry(gw, gh);
            end
            run_image($urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(8, 2),
                      $urandom_range(40, 4), $urandom_range(100), 2);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
